### hw/rtl/masked_event_router_macros.svh
// Assertion shorthands used by the checker file.
`ifndef MASKED_EVENT_ROUTER_MACROS_SVH
`define MASKED_EVENT_ROUTER_MACROS_SVH

// Plain clocked assertion, quiet while reset is held.
`define MER_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication from a condition to a consequence.
`define MER_ASSERT_IMPL(label, ante, cons, msg) \
  `MER_ASSERT(label, (ante) |-> (cons), msg)

`endif

### hw/rtl/mer_pkg.sv
package mer_pkg;

  localparam int WORD_BITS       = 32;
  localparam int EV_W            = 6;
  localparam int NUM_TARGETS     = 3;
  localparam int MASK_WORDS_DEF  = 2;
  localparam int IN_TDATA_W      = 48;
  localparam int OUT_TDATA_W     = 48;

  typedef enum logic [1:0] {
    OP_BUS_READ  = 2'd0,
    OP_BUS_WRITE = 2'd1,
    OP_EVENT     = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  localparam logic [2:0] SEL_TRIGGER    = 3'd0;
  localparam logic [2:0] SEL_CTRL_LO    = 3'd2;
  localparam logic [2:0] SEL_CLUSTER_LO = 3'd4;
  localparam logic [2:0] SEL_UNMAPPED   = 3'd7;

  localparam logic [3:0] ACCESS_OK_BYTES = 4'd4;
  localparam logic [5:0] MAX_SW_COUNT    = 6'd32;

  localparam logic [1:0] CFG_SW_BASE  = 2'd0;
  localparam logic [1:0] CFG_SW_COUNT = 2'd1;
  localparam logic [1:0] CFG_TICK_EV  = 2'd2;

  localparam logic KIND_BUS   = 1'b0;
  localparam logic KIND_EVENT = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic emit_walk;
    logic emit_resp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_start;
    logic walk_done;
    logic bit_hit;
    logic out_free;
  } dp_stat_t;

endpackage

### hw/rtl/mer_ctrl.sv
module mer_ctrl import mer_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  dp_stat_t   stat_i,
  output logic       s_ready_o,
  output ctrl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_RESP = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d   = state_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      ST_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = stat_i.walk_start ? ST_WALK : ST_RESP;
        end
      end
      ST_WALK: begin
        // One trigger data bit is examined per cycle; a set bit waits for
        // room in the output register.
        if (stat_i.walk_done) begin
          state_d = ST_RESP;
        end else if (!stat_i.bit_hit) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.step      = 1'b1;
          cmd_o.emit_walk = 1'b1;
        end
      end
      ST_RESP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_resp = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### hw/rtl/mer_dp.sv
module mer_dp import mer_pkg::*; #(
  parameter int MASK_WORDS = MASK_WORDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [EV_W-1:0]        cfg_wdata_i,
  input  logic [1:0]             in_op_i,
  input  logic [2:0]             in_sel_i,
  input  logic [3:0]             in_bytes_i,
  input  logic [WORD_BITS-1:0]   in_wdata_i,
  input  logic [EV_W-1:0]        in_event_i,
  input  ctrl_cmd_t              cmd_i,
  output dp_stat_t               stat_o,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic                   out_kind_o,
  output logic [EV_W-1:0]        out_event_o,
  output logic                   out_ctrl_o,
  output logic                   out_cluster_o,
  output logic                   out_periph_o,
  output logic                   out_tick_o,
  output logic [WORD_BITS-1:0]   out_rdata_o,
  output logic                   out_status_o,
  output logic                   out_last_o
);

  localparam int MaskBits = WORD_BITS * MASK_WORDS;
  localparam int BitIdxW  = $clog2(MaskBits);
  localparam logic [EV_W:0] Limit = (EV_W + 1)'(MaskBits);

  // Configuration registers.
  logic [EV_W-1:0] base_q, count_q, tick_ev_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      count_q   <= '0;
      tick_ev_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SW_BASE:  base_q    <= cfg_wdata_i;
        CFG_SW_COUNT: count_q   <= cfg_wdata_i;
        CFG_TICK_EV:  tick_ev_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Latched item.
  logic [1:0]           op_q;
  logic [2:0]           sel_q;
  logic [3:0]           bytes_q;
  logic [WORD_BITS-1:0] wdata_q;
  logic [EV_W-1:0]      event_q;
  logic [EV_W-1:0]      idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q    <= in_op_i;
      sel_q   <= in_sel_i;
      bytes_q <= in_bytes_i;
      wdata_q <= in_wdata_i;
      event_q <= in_event_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (cmd_i.load) begin
      idx_q <= '0;
    end else if (cmd_i.step) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // Trigger walk.
  logic [EV_W-1:0] count_eff;
  logic [EV_W:0]   walk_ev;
  logic            walk_done;

  assign count_eff = (count_q > MAX_SW_COUNT) ? MAX_SW_COUNT : count_q;
  assign walk_done = (idx_q >= count_eff);
  assign walk_ev   = {1'b0, base_q} + {1'b0, idx_q};

  assign stat_o.walk_start = (in_op_i == OP_BUS_WRITE) && (in_sel_i == SEL_TRIGGER)
                             && (in_bytes_i == ACCESS_OK_BYTES);
  assign stat_o.walk_done  = walk_done;
  assign stat_o.bit_hit    = wdata_q[idx_q[4:0]] && (walk_ev < Limit);
  assign stat_o.out_free   = !out_valid_o || out_ready_i;

  // Bus access decode.
  logic       hi_sel;
  logic [1:0] tgt;
  logic       acc_ok;
  logic       is_read, wr_access, is_bus;

  assign hi_sel    = sel_q[0];
  assign tgt       = (sel_q <= SEL_CTRL_LO) ? 2'd0 : ((sel_q <= SEL_CLUSTER_LO) ? 2'd1 : 2'd2);
  assign is_read   = (op_q == OP_BUS_READ);
  assign wr_access = (op_q == OP_BUS_WRITE);
  assign is_bus    = is_read || wr_access;
  assign acc_ok    = (bytes_q == ACCESS_OK_BYTES) && (sel_q != SEL_UNMAPPED)
                     && !((sel_q == SEL_TRIGGER) && is_read)
                     && !((sel_q != SEL_TRIGGER) && hi_sel && (MASK_WORDS < 2));

  logic mask_wr;
  assign mask_wr = cmd_i.emit_resp && wr_access && acc_ok && (sel_q != SEL_TRIGGER);

  // Mask storage, one word per 32-bit half; a set bit blocks the event.
  logic [MASK_WORDS-1:0][WORD_BITS-1:0] mask_q [NUM_TARGETS];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int t = 0; t < NUM_TARGETS; t++) begin
        mask_q[t] <= '1;
      end
    end else if (mask_wr) begin
      for (int t = 0; t < NUM_TARGETS; t++) begin
        for (int w = 0; w < MASK_WORDS; w++) begin
          if ((tgt == 2'(t)) && (hi_sel == (w != 0))) begin
            mask_q[t][w] <= wdata_q;
          end
        end
      end
    end
  end

  logic [WORD_BITS-1:0] rd_word;

  always_comb begin
    rd_word = '0;
    for (int t = 0; t < NUM_TARGETS; t++) begin
      for (int w = 0; w < MASK_WORDS; w++) begin
        if ((tgt == 2'(t)) && (hi_sel == (w != 0))) begin
          rd_word = mask_q[t][w];
        end
      end
    end
  end

  // Routing lookup for the event currently being delivered.
  logic [EV_W-1:0]        route_ev;
  logic                   route_in_range;
  logic [NUM_TARGETS-1:0] route_hit;
  logic [MaskBits-1:0]    flat_mask [NUM_TARGETS];

  assign route_ev = cmd_i.emit_walk ? walk_ev[EV_W-1:0]
                  : ((op_q == OP_TICK) ? tick_ev_q : event_q);
  assign route_in_range = ({1'b0, route_ev} < Limit);

  always_comb begin
    for (int t = 0; t < NUM_TARGETS; t++) begin
      flat_mask[t] = mask_q[t];
      route_hit[t] = route_in_range && !flat_mask[t][route_ev[BitIdxW-1:0]];
    end
  end

  // Output register.
  logic                 valid_q;
  logic                 kind_q, ctrl_q, cluster_q, periph_q, tick_q, status_q, last_q;
  logic [EV_W-1:0]      ev_q;
  logic [WORD_BITS-1:0] rdata_q;
  logic                 emit, resp_is_bus;

  assign emit        = cmd_i.emit_walk || cmd_i.emit_resp;
  assign resp_is_bus = cmd_i.emit_resp && is_bus;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (emit) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      if (resp_is_bus) begin
        kind_q    <= KIND_BUS;
        ev_q      <= '0;
        ctrl_q    <= 1'b0;
        cluster_q <= 1'b0;
        periph_q  <= 1'b0;
        tick_q    <= 1'b0;
        rdata_q   <= (is_read && acc_ok) ? rd_word : '0;
        status_q  <= !acc_ok;
      end else begin
        kind_q    <= KIND_EVENT;
        ev_q      <= route_ev;
        ctrl_q    <= route_hit[0];
        cluster_q <= route_hit[1];
        periph_q  <= route_hit[2];
        tick_q    <= cmd_i.emit_resp && (op_q == OP_TICK);
        rdata_q   <= '0;
        status_q  <= 1'b0;
      end
      last_q <= cmd_i.emit_resp;
    end
  end

  assign out_valid_o   = valid_q;
  assign out_kind_o    = kind_q;
  assign out_event_o   = ev_q;
  assign out_ctrl_o    = ctrl_q;
  assign out_cluster_o = cluster_q;
  assign out_periph_o  = periph_q;
  assign out_tick_o    = tick_q;
  assign out_rdata_o   = rdata_q;
  assign out_status_o  = status_q;
  assign out_last_o    = last_q;

endmodule

### hw/rtl/masked_event_router.sv
// An accepted item is latched, then passes through the walk state (trigger writes only) and the response state.
// No new item is taken until the response state has registered the item's last result.
// A trigger write examines one data bit per walk cycle; a set bit waits for room in the output register.
// Output stalls hold the walk and the response; the next item is taken while the last result waits.
// Reset: all masks to all ones, configuration registers to zero, output register empty.
module masked_event_router import mer_pkg::*; #(
  parameter int MASK_WORDS = MASK_WORDS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [EV_W-1:0]        cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // reg_sel[2:0], access_bytes[6:3], write_data[38:7], event_num[44:39], zero fill
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]             s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // out_event[5:0], to_controller[6], to_cluster[7], to_periph[8], tick_pulse[9],
  // read_data[41:10], status[42], zero fill
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // kind[0]
  output logic                   m_axis_tuser_o,
  output logic                   m_axis_tlast_o
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  logic                 out_ctrl, out_cluster, out_periph, out_tick, out_status;
  logic [EV_W-1:0]      out_event;
  logic [WORD_BITS-1:0] out_rdata;

  mer_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .stat_i    (stat),
    .s_ready_o (s_axis_tready_o),
    .cmd_o     (cmd)
  );

  mer_dp #(
    .MASK_WORDS (MASK_WORDS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_op_i       (s_axis_tuser_i),
    .in_sel_i      (s_axis_tdata_i[2:0]),
    .in_bytes_i    (s_axis_tdata_i[6:3]),
    .in_wdata_i    (s_axis_tdata_i[38:7]),
    .in_event_i    (s_axis_tdata_i[44:39]),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (m_axis_tready_i),
    .out_valid_o   (m_axis_tvalid_o),
    .out_kind_o    (m_axis_tuser_o),
    .out_event_o   (out_event),
    .out_ctrl_o    (out_ctrl),
    .out_cluster_o (out_cluster),
    .out_periph_o  (out_periph),
    .out_tick_o    (out_tick),
    .out_rdata_o   (out_rdata),
    .out_status_o  (out_status),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {5'b0, out_status, out_rdata, out_tick, out_periph, out_cluster,
                           out_ctrl, out_event};

endmodule

### hw/rtl/mer_checker.sv
`include "masked_event_router_macros.svh"

module mer_checker import mer_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  input  logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                   m_axis_tuser_o,
  input  logic                   m_axis_tlast_o
);

  `MER_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `MER_ASSERT_IMPL(a_bus_last, m_axis_tvalid_o && (m_axis_tuser_o == KIND_BUS), m_axis_tlast_o, "bus response not last")
  `MER_ASSERT_IMPL(a_bus_clean, m_axis_tvalid_o && (m_axis_tuser_o == KIND_BUS), m_axis_tdata_o[9:0] == 10'd0, "bus response carries event fields")
  `MER_ASSERT_IMPL(a_tick_event, m_axis_tvalid_o && m_axis_tdata_o[9], (m_axis_tuser_o == KIND_EVENT) && m_axis_tlast_o, "tick pulse outside a single routed event")
  `MER_ASSERT_IMPL(a_event_clean, m_axis_tvalid_o && (m_axis_tuser_o == KIND_EVENT), m_axis_tdata_o[42:10] == 33'd0, "routed event carries bus fields")

endmodule

bind masked_event_router mer_checker u_mer_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

### sim/tb_masked_event_router.sv
`timescale 1ns / 1ps

module tb_masked_event_router;
  import mer_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 10;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_ITEMS = 340;
  localparam int NUM_EVENTS   = WORD_BITS * MASK_WORDS_DEF;

  localparam logic [2:0] SEL_CTRL_HI    = 3'd1;
  localparam logic [2:0] SEL_CLUSTER_HI = 3'd3;
  localparam logic [2:0] SEL_PERIPH_HI  = 3'd5;
  localparam logic [2:0] SEL_PERIPH_LO  = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [5:0]  event_num;
    logic        to_ctrl;
    logic        to_cluster;
    logic        to_periph;
    logic        tick;
    logic [31:0] rdata;
    logic        status;
    logic        last;
  } router_out_t;

  logic                   clk_i;
  logic                   rst_ni          = 1'b0;
  logic                   cfg_we_i        = 1'b0;
  logic [1:0]             cfg_idx_i       = '0;
  logic [EV_W-1:0]        cfg_wdata_i     = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [1:0]             s_axis_tuser_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tlast_o;

  // Shadow copy of the router state and its configuration.
  logic [63:0] mask_ctrl    = '1;
  logic [63:0] mask_cluster = '1;
  logic [63:0] mask_periph  = '1;
  logic [5:0]  cfg_base     = '0;
  logic [5:0]  cfg_count    = '0;
  logic [5:0]  cfg_tick     = '0;

  router_out_t expected_outputs[$];

  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int mismatches      = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int events_routed   = 0;
  int bus_responses   = 0;
  int config_writes   = 0;

  masked_event_router dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                results_checked, name, got, want));
    end
  endtask

  function automatic router_out_t routed(input logic [5:0] ev, input logic tick);
    router_out_t r;
    r            = '0;
    r.kind       = KIND_EVENT;
    r.event_num  = ev;
    r.to_ctrl    = ~mask_ctrl[ev];
    r.to_cluster = ~mask_cluster[ev];
    r.to_periph  = ~mask_periph[ev];
    r.tick       = tick;
    return r;
  endfunction

  // Works out every result that one accepted item causes and updates the masks.
  task automatic predict_routing(input op_e op, input logic [2:0] sel,
                                 input logic [3:0] nbytes, input logic [31:0] data,
                                 input logic [5:0] ev);
    router_out_t batch[$];
    router_out_t resp;
    int          walk;
    int          evn;
    int          half;
    resp      = '0;
    resp.kind = KIND_BUS;
    case (op)
      OP_EVENT: batch.push_back(routed(ev, 1'b0));
      OP_TICK:  batch.push_back(routed(cfg_tick, 1'b1));
      default: begin
        if (nbytes != ACCESS_OK_BYTES || sel == SEL_UNMAPPED) begin
          resp.status = 1'b1;
        end else if (sel == SEL_TRIGGER) begin
          if (op == OP_BUS_READ) begin
            resp.status = 1'b1;
          end else begin
            walk = (cfg_count > MAX_SW_COUNT) ? int'(MAX_SW_COUNT) : int'(cfg_count);
            for (int i = 0; i < walk; i++) begin
              evn = int'(cfg_base) + i;
              // Event numbers past the top of the mask are silently dropped.
              if (data[i] && evn < NUM_EVENTS) batch.push_back(routed(6'(evn), 1'b0));
            end
          end
        end else begin
          half = (sel == SEL_CTRL_HI || sel == SEL_CLUSTER_HI || sel == SEL_PERIPH_HI)
                 ? WORD_BITS : 0;
          if (op == OP_BUS_WRITE) begin
            if (sel <= SEL_CTRL_LO) mask_ctrl[half +: WORD_BITS] = data;
            else if (sel <= SEL_CLUSTER_LO) mask_cluster[half +: WORD_BITS] = data;
            else mask_periph[half +: WORD_BITS] = data;
          end else begin
            if (sel <= SEL_CTRL_LO) resp.rdata = mask_ctrl[half +: WORD_BITS];
            else if (sel <= SEL_CLUSTER_LO) resp.rdata = mask_cluster[half +: WORD_BITS];
            else resp.rdata = mask_periph[half +: WORD_BITS];
          end
        end
        batch.push_back(resp);
      end
    endcase
    batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_outputs.push_back(batch[i]);
  endtask

  // Valid stays high from one item to the next when no gap is drawn, so this task
  // only lowers it at the start of a gap.
  task automatic send_item(input op_e op, input logic [2:0] sel, input logic [3:0] nbytes,
                           input logic [31:0] data, input logic [5:0] ev);
    int gap;
    gap = send_idle ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, ev, data, nbytes, sel};
    s_axis_tuser_i  <= op;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predict_routing(op, sel, nbytes, data, ev);
    items_sent++;
  endtask

  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_outputs.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [5:0] value);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SW_BASE:  cfg_base  = value;
      CFG_SW_COUNT: cfg_count = value;
      CFG_TICK_EV:  cfg_tick  = value;
      default: ;
    endcase
    config_writes++;
    @(posedge clk_i);
  endtask

  task automatic test_reset_state();
    send_item(OP_BUS_READ, SEL_CTRL_HI, ACCESS_OK_BYTES, '0, '0);
    send_item(OP_BUS_READ, SEL_CLUSTER_LO, ACCESS_OK_BYTES, '0, '0);
    send_item(OP_BUS_READ, SEL_PERIPH_LO, ACCESS_OK_BYTES, '0, '0);
    // Every target masks everything after reset; the event still comes out.
    send_item(OP_EVENT, SEL_TRIGGER, ACCESS_OK_BYTES, '0, 6'd0);
  endtask

  task automatic test_invalid_access();
    send_item(OP_BUS_READ, SEL_CTRL_LO, 4'd1, '0, '0);
    // A wrong-size write must leave the mask untouched.
    send_item(OP_BUS_WRITE, SEL_CTRL_LO, 4'd8, '0, '0);
    send_item(OP_BUS_READ, SEL_CTRL_LO, ACCESS_OK_BYTES, '0, '0);
    send_item(OP_BUS_READ, SEL_TRIGGER, ACCESS_OK_BYTES, '0, '0);
    send_item(OP_BUS_WRITE, SEL_UNMAPPED, ACCESS_OK_BYTES, '1, '0);
    send_item(OP_BUS_READ, SEL_UNMAPPED, ACCESS_OK_BYTES, '0, '0);
  endtask

  task automatic test_mask_routing();
    send_item(OP_BUS_WRITE, SEL_CTRL_LO, ACCESS_OK_BYTES, 32'h0000_0000, '0);
    send_item(OP_BUS_WRITE, SEL_CLUSTER_HI, ACCESS_OK_BYTES, 32'h0000_0000, '0);
    send_item(OP_BUS_WRITE, SEL_PERIPH_LO, ACCESS_OK_BYTES, 32'haaaa_aaaa, '0);
    send_item(OP_BUS_WRITE, SEL_PERIPH_HI, ACCESS_OK_BYTES, 32'h5555_5555, '0);
    send_item(OP_EVENT, SEL_TRIGGER, ACCESS_OK_BYTES, '0, 6'd0);
    send_item(OP_EVENT, SEL_TRIGGER, ACCESS_OK_BYTES, '0, 6'd63);
    send_item(OP_EVENT, SEL_TRIGGER, ACCESS_OK_BYTES, '0, 6'd33);
    send_item(OP_BUS_READ, SEL_PERIPH_HI, ACCESS_OK_BYTES, '0, '0);
    send_item(OP_TICK, SEL_TRIGGER, ACCESS_OK_BYTES, '0, '0);
  endtask

  task automatic test_trigger_walk();
    settle_block();
    write_cfg(CFG_SW_BASE, 6'd0);
    write_cfg(CFG_SW_COUNT, 6'd32);
    send_item(OP_BUS_WRITE, SEL_TRIGGER, ACCESS_OK_BYTES, '1, '0);
    // Count above the word width is clamped; only event 63 stays in range.
    settle_block();
    write_cfg(CFG_SW_BASE, 6'd63);
    write_cfg(CFG_SW_COUNT, 6'd63);
    send_item(OP_BUS_WRITE, SEL_TRIGGER, ACCESS_OK_BYTES, '1, '0);
    settle_block();
    write_cfg(CFG_SW_COUNT, 6'd0);
    send_item(OP_BUS_WRITE, SEL_TRIGGER, ACCESS_OK_BYTES, '1, '0);
    settle_block();
    write_cfg(CFG_SW_BASE, 6'd40);
    write_cfg(CFG_SW_COUNT, 6'd5);
    write_cfg(CFG_TICK_EV, 6'd63);
    send_item(OP_BUS_WRITE, SEL_TRIGGER, ACCESS_OK_BYTES, 32'h0000_0015, '0);
    send_item(OP_TICK, SEL_TRIGGER, ACCESS_OK_BYTES, '0, '0);
  endtask

  task automatic randomize_config();
    case ($urandom_range(0, 3))
      0:       write_cfg(CFG_SW_BASE, 6'd0);
      1:       write_cfg(CFG_SW_BASE, 6'd63);
      default: write_cfg(CFG_SW_BASE, 6'($urandom_range(0, 63)));
    endcase
    case ($urandom_range(0, 4))
      0:       write_cfg(CFG_SW_COUNT, 6'd0);
      1:       write_cfg(CFG_SW_COUNT, MAX_SW_COUNT);
      2:       write_cfg(CFG_SW_COUNT, 6'($urandom_range(33, 63)));
      default: write_cfg(CFG_SW_COUNT, 6'($urandom_range(1, 32)));
    endcase
    write_cfg(CFG_TICK_EV, 6'($urandom_range(0, 63)));
  endtask

  task automatic send_random_item();
    int          pick;
    op_e         op;
    logic [2:0]  sel;
    logic [3:0]  nbytes;
    logic [31:0] data;
    pick = $urandom_range(0, 99);
    if (pick < 30) op = OP_EVENT;
    else if (pick < 40) op = OP_TICK;
    else if (pick < 70) op = OP_BUS_WRITE;
    else op = OP_BUS_READ;
    sel    = ($urandom_range(0, 3) == 0) ? SEL_TRIGGER : 3'($urandom_range(0, 7));
    nbytes = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(1, 8)) : ACCESS_OK_BYTES;
    case ($urandom_range(0, 3))
      0:       data = '0;
      1:       data = '1;
      default: data = $urandom();
    endcase
    send_item(op, sel, nbytes, data, 6'($urandom_range(0, 63)));
  endtask

  task automatic test_random_traffic();
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 40 == 0) begin
        settle_block();
        randomize_config();
        send_idle = ($urandom_range(0, 3) != 0);
        recv_idle = ($urandom_range(0, 3) != 0);
      end else if ($urandom_range(0, 29) == 0) begin
        // Hold off until the output side has caught up completely.
        settle_block();
      end
      send_random_item();
    end
  endtask

  initial begin : result_checker
    int          stall;
    router_out_t got;
    router_out_t want;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      stall = recv_idle ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      got.kind       = m_axis_tuser_o;
      got.event_num  = m_axis_tdata_o[5:0];
      got.to_ctrl    = m_axis_tdata_o[6];
      got.to_cluster = m_axis_tdata_o[7];
      got.to_periph  = m_axis_tdata_o[8];
      got.tick       = m_axis_tdata_o[9];
      got.rdata      = m_axis_tdata_o[41:10];
      got.status     = m_axis_tdata_o[42];
      got.last       = m_axis_tlast_o;
      if (expected_outputs.size() == 0) begin
        report_mismatch($sformatf("unexpected result 0x%0h", got));
      end else begin
        want = expected_outputs.pop_front();
        check_field("kind", got.kind, want.kind);
        check_field("out_event", got.event_num, want.event_num);
        check_field("to_controller", got.to_ctrl, want.to_ctrl);
        check_field("to_cluster", got.to_cluster, want.to_cluster);
        check_field("to_periph", got.to_periph, want.to_periph);
        check_field("tick_pulse", got.tick, want.tick);
        check_field("read_data", got.rdata, want.rdata);
        check_field("status", got.status, want.status);
        check_field("last", got.last, want.last);
        if (want.kind == KIND_EVENT) events_routed++;
        else bus_responses++;
      end
      results_checked++;
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_axis_tvalid_i && s_axis_tready_o) ||
          (m_axis_tvalid_o && m_axis_tready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             QUIET_LIMIT, expected_outputs.size());
    $display("FAILED: results differ");
    $finish;
  end

  initial begin : main_sequence
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_state();
    test_invalid_access();
    test_mask_routing();
    test_trigger_walk();
    test_random_traffic();
    settle_block();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_outputs.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_outputs.size()));
    end
    $display("Sent %0d items over %0d configuration writes; checked %0d results.",
             items_sent, config_writes, results_checked);
    $display("Of those, %0d were routed events and %0d bus responses; %0d mismatches.",
             events_routed, bus_responses, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
